### rtl/brht_pkg.sv
`default_nettype none

package brht_pkg;

    // table depth
    localparam int MAX_BUTTONS = 16;

    // field widths
    localparam int COORD_W = 12;
    localparam int EDGE_W  = COORD_W + 1;
    localparam int OP_W    = 2;
    localparam int HIT_W   = 5;

    // entry count holds 0..MAX_BUTTONS, slot index addresses one cell
    localparam int CNT_W  = $clog2(MAX_BUTTONS + 1);
    localparam int SLOT_W = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;

    // operation codes
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // per-cell control from the table
    typedef struct packed {
        logic wr;
        logic probe;
        logic live;
    } cell_ctl_t;

endpackage

`default_nettype wire

### rtl/brht_cell.sv
`default_nettype none

module brht_cell (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire brht_pkg::cell_ctl_t            ctl,
    input  wire logic [brht_pkg::COORD_W-1:0]   pos_x,
    input  wire logic [brht_pkg::COORD_W-1:0]   pos_y,
    input  wire logic [brht_pkg::COORD_W-1:0]   box_width,
    input  wire logic [brht_pkg::COORD_W-1:0]   box_height,
    input  wire logic                           any_in,
    output logic                                any_out,
    output logic                                first
);

    logic [brht_pkg::COORD_W-1:0] left_reg;
    logic [brht_pkg::COORD_W-1:0] top_reg;
    logic [brht_pkg::EDGE_W-1:0]  right_reg;
    logic [brht_pkg::EDGE_W-1:0]  bottom_reg;
    logic                         match_reg;
    logic                         match_next;

    // rectangle store, far edges kept at 13 bits so they never wrap
    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            left_reg   <= pos_x;
            top_reg    <= pos_y;
            right_reg  <= {1'b0, pos_x} + {1'b0, box_width};
            bottom_reg <= {1'b0, pos_y} + {1'b0, box_height};
        end
    end

    // inclusive containment test against the probe point
    always_comb
    begin
        match_next = ctl.live
                     && (pos_x >= left_reg) && ({1'b0, pos_x} <= right_reg)
                     && (pos_y >= top_reg)  && ({1'b0, pos_y} <= bottom_reg);
    end

    // test refreshed at each request, held until the next one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (ctl.probe)
        begin
            match_reg <= match_next;
        end
    end

    // earlier cells win: pass "already hit" down the chain
    assign any_out = any_in | match_reg;
    assign first   = match_reg & ~any_in;

endmodule

`default_nettype wire

### rtl/brht_table.sv
`default_nettype none

module brht_table (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [brht_pkg::OP_W-1:0]      operation,
    input  wire logic [brht_pkg::COORD_W-1:0]   pos_x,
    input  wire logic [brht_pkg::COORD_W-1:0]   pos_y,
    input  wire logic [brht_pkg::COORD_W-1:0]   box_width,
    input  wire logic [brht_pkg::COORD_W-1:0]   box_height,
    output logic                                full,
    output logic [brht_pkg::HIT_W-1:0]          hit_index
);

    logic [brht_pkg::CNT_W-1:0]       count_reg;
    logic [brht_pkg::CNT_W-1:0]       count_next;
    logic                             do_append;
    logic                             do_probe;
    logic [brht_pkg::MAX_BUTTONS:0]   any_chain;
    logic [brht_pkg::MAX_BUTTONS-1:0] first_vec;
    brht_pkg::cell_ctl_t              ctl [brht_pkg::MAX_BUTTONS];

    assign full      = (count_reg == brht_pkg::CNT_W'(brht_pkg::MAX_BUTTONS));
    assign do_append = start && (operation == brht_pkg::OP_APPEND) && !full;
    assign do_probe  = start && (operation == brht_pkg::OP_QUERY);

    // fill count
    always_comb
    begin
        count_next = count_reg;
        if (start && (operation == brht_pkg::OP_CLEAR))
        begin
            count_next = '0;
        end
        else if (do_append)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign any_chain[0] = 1'b0;

    // row of cells, one rectangle each; every request refreshes the tests,
    // only a query on a stored entry can match
    for (genvar k = 0; k < brht_pkg::MAX_BUTTONS; k++)
    begin : g_cell
        always_comb
        begin
            ctl[k].wr    = do_append && (count_reg == brht_pkg::CNT_W'(k));
            ctl[k].probe = start;
            ctl[k].live  = do_probe && (brht_pkg::CNT_W'(k) < count_reg);
        end

        brht_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl[k]),
            .pos_x      (pos_x),
            .pos_y      (pos_y),
            .box_width  (box_width),
            .box_height (box_height),
            .any_in     (any_chain[k]),
            .any_out    (any_chain[k+1]),
            .first      (first_vec[k])
        );
    end

    // at most one first hit: or together its 1-based position
    always_comb
    begin
        hit_index = '0;
        for (int k = 0; k < brht_pkg::MAX_BUTTONS; k++)
        begin
            if (first_vec[k])
            begin
                hit_index = hit_index | brht_pkg::HIT_W'(k + 1);
            end
        end
    end

endmodule

`default_nettype wire

### rtl/button_region_hit_table.sv
`default_nettype none

// channel  | signals                                         | dir
// ---------+-------------------------------------------------+-----
// request  | in_valid in_ready operation pos_x pos_y         | in
//          | box_width box_height                            |
// result   | out_valid out_ready hit_index status            | out
//
// The cells register their containment tests at the accept edge, and the
// first-hit chain resolves in the next cycle; the result loads in the
// evaluate state once the output register is free. Append and clear update
// the table at the accept edge. Reset empties the table; stored rectangles
// are not cleared. A request is taken while the previous result still waits
// in the output register; a new result then waits in the evaluate state.

module button_region_hit_table (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [brht_pkg::OP_W-1:0]      operation,
    input  wire logic [brht_pkg::COORD_W-1:0]   pos_x,
    input  wire logic [brht_pkg::COORD_W-1:0]   pos_y,
    input  wire logic [brht_pkg::COORD_W-1:0]   box_width,
    input  wire logic [brht_pkg::COORD_W-1:0]   box_height,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [brht_pkg::HIT_W-1:0]          hit_index,
    output logic                                status
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EVAL = 1'b1;

    logic                         state_reg;
    logic                         state_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [brht_pkg::HIT_W-1:0]   hit_reg;
    logic                         status_reg;
    logic                         status_pend_reg;
    logic                         status_pend_next;
    logic                         accept;
    logic                         load;
    logic                         full;
    logic [brht_pkg::HIT_W-1:0]   table_hit;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign load     = (state_reg == ST_EVAL) && (!out_valid_reg || out_ready);

    brht_table u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (accept),
        .operation  (operation),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .box_width  (box_width),
        .box_height (box_height),
        .full       (full),
        .hit_index  (table_hit)
    );

    // sequencer and output handshake
    always_comb
    begin
        state_next       = state_reg;
        out_valid_next   = out_valid_reg;
        status_pend_next = status_pend_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next       = ST_EVAL;
                    status_pend_next = (operation == brht_pkg::OP_APPEND) && full;
                end
            end
            ST_EVAL:
            begin
                if (load)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            status_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            out_valid_reg   <= out_valid_next;
            status_pend_reg <= status_pend_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hit_reg    <= table_hit;
            status_reg <= status_pend_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit_index = hit_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire

### bench/tb.sv
`default_nettype none

module tb;

    typedef logic [brht_pkg::OP_W-1:0]    op_t;
    typedef logic [brht_pkg::COORD_W-1:0] coord_t;
    typedef logic [brht_pkg::HIT_W-1:0]   hit_t;

    // code the block leaves unused: no state change, empty result
    localparam op_t OP_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS  = 620;
    localparam int HOLD_CYCLES   = 80;
    localparam int DRAIN_CYCLES  = 12;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DIRECTED_ROWS = 23;
    localparam int COORD_MAX     = (1 << brht_pkg::COORD_W) - 1;

    typedef struct packed {
        hit_t hit;
        logic status;
    } outcome_t;

    typedef struct packed {
        op_t        op;
        coord_t     x;
        coord_t     y;
        coord_t     w;
        coord_t     h;
        logic [4:0] reps;
        logic       typed;
        hit_t       hit;
        logic       status;
    } stim_row_t;

    typedef enum int {
        PH_STEADY,
        PH_SRC_IDLE,
        PH_SINK_STALL,
        PH_BOTH,
        PH_BACKLOG
    } run_phase_t;

    // directed requests: op, x, y, w, h, repeats, typed, hit, status
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        // empty table, unused code, clear with every field bit set
        '{brht_pkg::OP_QUERY,  12'd5,   12'd5,   12'd0,   12'd0,   5'd1,  1'b1, 5'd0, 1'b0},
        '{OP_UNUSED,           12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 5'd1,  1'b1, 5'd0, 1'b0},
        '{brht_pkg::OP_CLEAR,  12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 5'd1,  1'b1, 5'd0, 1'b0},
        // zero-size rectangle at the origin holds only its point
        '{brht_pkg::OP_APPEND, 12'd0,   12'd0,   12'd0,   12'd0,   5'd1,  1'b1, 5'd0, 1'b0},
        '{brht_pkg::OP_QUERY,  12'd0,   12'd0,   12'd0,   12'd0,   5'd1,  1'b0, 5'd0, 1'b0},
        '{brht_pkg::OP_QUERY,  12'd1,   12'd0,   12'd0,   12'd0,   5'd1,  1'b0, 5'd0, 1'b0},
        '{brht_pkg::OP_QUERY,  12'd0,   12'd1,   12'd0,   12'd0,   5'd1,  1'b0, 5'd0, 1'b0},
        // largest rectangle, edge sums past the coordinate range
        '{brht_pkg::OP_APPEND, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 5'd1,  1'b1, 5'd0, 1'b0},
        '{brht_pkg::OP_QUERY,  12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 5'd1,  1'b0, 5'd0, 1'b0},
        // zero-width line, hit on its bottom end, miss beside it
        '{brht_pkg::OP_APPEND, 12'd100, 12'd200, 12'd0,   12'd50,  5'd1,  1'b1, 5'd0, 1'b0},
        '{brht_pkg::OP_QUERY,  12'd100, 12'd250, 12'd0,   12'd0,   5'd1,  1'b0, 5'd0, 1'b0},
        '{brht_pkg::OP_QUERY,  12'd101, 12'd220, 12'd0,   12'd0,   5'd1,  1'b0, 5'd0, 1'b0},
        // overlapping box: far corner, then shared corner where the first wins
        '{brht_pkg::OP_APPEND, 12'd100, 12'd200, 12'd300, 12'd400, 5'd1,  1'b1, 5'd0, 1'b0},
        '{brht_pkg::OP_QUERY,  12'd400, 12'd600, 12'd0,   12'd0,   5'd1,  1'b0, 5'd0, 1'b0},
        '{brht_pkg::OP_QUERY,  12'd100, 12'd200, 12'd0,   12'd0,   5'd1,  1'b0, 5'd0, 1'b0},
        // fill up, then one append too many
        '{brht_pkg::OP_APPEND, 12'hAAA, 12'h555, 12'h555, 12'hAAA, 5'd12, 1'b1, 5'd0, 1'b0},
        '{brht_pkg::OP_APPEND, 12'd1,   12'd2,   12'd3,   12'd4,   5'd1,  1'b1, 5'd0, 1'b1},
        '{brht_pkg::OP_QUERY,  12'hAAA, 12'h555, 12'h555, 12'hAAA, 5'd1,  1'b0, 5'd0, 1'b0},
        '{brht_pkg::OP_QUERY,  12'hFFF, 12'd0,   12'd0,   12'd0,   5'd1,  1'b0, 5'd0, 1'b0},
        // clear empties the table
        '{brht_pkg::OP_CLEAR,  12'd0,   12'd0,   12'd0,   12'd0,   5'd1,  1'b1, 5'd0, 1'b0},
        '{brht_pkg::OP_QUERY,  12'd0,   12'd0,   12'd0,   12'd0,   5'd1,  1'b1, 5'd0, 1'b0},
        '{brht_pkg::OP_APPEND, 12'hFFF, 12'd0,   12'd0,   12'hFFF, 5'd1,  1'b1, 5'd0, 1'b0},
        '{brht_pkg::OP_QUERY,  12'hFFF, 12'hFFF, 12'd0,   12'd0,   5'd1,  1'b0, 5'd0, 1'b0}
    };

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    op_t                 operation;
    coord_t              pos_x;
    coord_t              pos_y;
    coord_t              box_width;
    coord_t              box_height;
    logic                out_valid;
    logic                out_ready;
    hit_t                hit_index;
    logic                status;

    // shadow of the button table
    coord_t              panel_left   [brht_pkg::MAX_BUTTONS];
    coord_t              panel_top    [brht_pkg::MAX_BUTTONS];
    coord_t              panel_span_x [brht_pkg::MAX_BUTTONS];
    coord_t              panel_span_y [brht_pkg::MAX_BUTTONS];
    int                  panel_count = 0;

    outcome_t            pending_outcomes [$];
    run_phase_t          phase = PH_STEADY;
    int                  requests_sent = 0;
    int                  queries_sent = 0;
    int                  appends_sent = 0;
    int                  results_seen = 0;
    int                  hits_seen = 0;
    int                  drops_seen = 0;
    int                  error_count = 0;
    int                  cycle_count = 0;
    int                  hold_count = 0;

    button_region_hit_table dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .box_width  (box_width),
        .box_height (box_height),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hit_index  (hit_index),
        .status     (status)
    );

    always #10 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_outcomes.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // apply one request to the shadow table and return its result
    function automatic outcome_t panel_step(input op_t op,
                                            input coord_t x,
                                            input coord_t y,
                                            input coord_t w,
                                            input coord_t h);
        outcome_t res;
        logic     found;
        int       k;
        res = '0;
        found = 1'b0;
        case (op)
            brht_pkg::OP_QUERY:
            begin
                // first stored box containing the point, edges inclusive
                for (k = 0; k < panel_count; k++)
                begin
                    if (!found && x >= panel_left[k] && y >= panel_top[k] &&
                        int'(x) <= int'(panel_left[k]) + int'(panel_span_x[k]) &&
                        int'(y) <= int'(panel_top[k]) + int'(panel_span_y[k]))
                    begin
                        res.hit = hit_t'(k + 1);
                        found = 1'b1;
                    end
                end
            end
            brht_pkg::OP_APPEND:
            begin
                if (panel_count >= brht_pkg::MAX_BUTTONS)
                    res.status = 1'b1;
                else
                begin
                    panel_left[panel_count]   = x;
                    panel_top[panel_count]    = y;
                    panel_span_x[panel_count] = w;
                    panel_span_y[panel_count] = h;
                    panel_count++;
                end
            end
            brht_pkg::OP_CLEAR:
                panel_count = 0;
            default:
                ;
        endcase
        return res;
    endfunction

    // offer one request, called and returning just after a falling edge
    task automatic send_request(input op_t op,
                                input coord_t x,
                                input coord_t y,
                                input coord_t w,
                                input coord_t h,
                                input bit use_typed = 1'b0,
                                input outcome_t typed = '0);
        int       idle_pct;
        int       gap;
        outcome_t predicted;
        idle_pct = (phase == PH_SRC_IDLE) ? 57 : (phase == PH_BOTH) ? 28 : 0;
        gap = 0;
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        pos_x      <= x;
        pos_y      <= y;
        box_width  <= w;
        box_height <= h;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = panel_step(op, x, y, w, h);
        pending_outcomes.push_back(use_typed ? typed : predicted);
        requests_sent++;
        if (op == brht_pkg::OP_QUERY)
            queries_sent++;
        if (op == brht_pkg::OP_APPEND)
            appends_sent++;
        @(negedge clk);
    endtask

    // result side readiness, with one long hold-off in the backlog phase
    always @(negedge clk)
    begin
        if (phase == PH_BACKLOG && hold_count < HOLD_CYCLES)
        begin
            out_ready <= 1'b0;
            hold_count++;
        end
        else if (phase == PH_SINK_STALL)
            out_ready <= ($urandom_range(99) >= 57);
        else if (phase == PH_BOTH)
            out_ready <= ($urandom_range(99) >= 28);
        else
            out_ready <= 1'b1;
    end

    // compare each result with the oldest expectation
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t: result with none expected: hit_index %0d status %0d",
                         $time, hit_index, status);
                error_count++;
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (hit_index !== want.hit)
                begin
                    $display("%0t: hit_index expected %0d got %0d", $time, want.hit,
                             hit_index);
                    error_count++;
                end
                if (status !== want.status)
                begin
                    $display("%0t: status expected %0d got %0d", $time, want.status,
                             status);
                    error_count++;
                end
                if (want.hit != 0)
                    hits_seen++;
                if (want.status)
                    drops_seen++;
            end
        end
    end

    initial
    begin
        stim_row_t row;
        int        r;
        int        k;
        int        lo;
        int        hi;
        int        random_base;
        int        slot;
        bit        clustered;
        coord_t    x;
        coord_t    y;
        coord_t    w;
        coord_t    h;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        operation  = brht_pkg::OP_QUERY;
        pos_x      = '0;
        pos_y      = '0;
        box_width  = '0;
        box_height = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed requests
        for (r = 0; r < DIRECTED_ROWS; r++)
        begin
            row = DIRECTED[r];
            repeat (row.reps)
                send_request(row.op, row.x, row.y, row.w, row.h, row.typed,
                             outcome_t'({row.hit, row.status}));
        end

        // random sessions: mostly fill then probe, some noise
        random_base = requests_sent;
        while (requests_sent - random_base < RANDOM_ITEMS)
        begin
            slot = (requests_sent - random_base) * 5 / RANDOM_ITEMS;
            phase = run_phase_t'(slot > 4 ? 4 : slot);
            if ($urandom_range(99) < 85)
            begin
                clustered = ($urandom_range(1) == 1);
                if ($urandom_range(99) < 80)
                    send_request(brht_pkg::OP_CLEAR, coord_t'($urandom), coord_t'($urandom),
                                 coord_t'($urandom), coord_t'($urandom));
                repeat ($urandom_range(brht_pkg::MAX_BUTTONS + 2, 1))
                begin
                    // clustered boxes overlap, so first-hit order matters
                    if (clustered)
                    begin
                        x = coord_t'($urandom_range(200));
                        y = coord_t'($urandom_range(200));
                        w = coord_t'($urandom_range(120));
                        h = coord_t'($urandom_range(120));
                    end
                    else
                    begin
                        x = coord_t'($urandom);
                        y = coord_t'($urandom);
                        w = ($urandom_range(3) == 0) ? coord_t'($urandom)
                                                     : coord_t'($urandom_range(400));
                        h = ($urandom_range(3) == 0) ? coord_t'($urandom)
                                                     : coord_t'($urandom_range(400));
                    end
                    send_request(brht_pkg::OP_APPEND, x, y, w, h);
                end
                repeat ($urandom_range(12, 4))
                begin
                    if (panel_count != 0 && $urandom_range(99) < 75)
                    begin
                        // aim inside a stored box, often right on an edge
                        k = $urandom_range(panel_count - 1);
                        lo = int'(panel_left[k]);
                        hi = lo + int'(panel_span_x[k]);
                        if (hi > COORD_MAX)
                            hi = COORD_MAX;
                        case ($urandom_range(3))
                            0: x = coord_t'(lo);
                            1: x = coord_t'(hi);
                            default: x = coord_t'($urandom_range(hi, lo));
                        endcase
                        lo = int'(panel_top[k]);
                        hi = lo + int'(panel_span_y[k]);
                        if (hi > COORD_MAX)
                            hi = COORD_MAX;
                        case ($urandom_range(3))
                            0: y = coord_t'(lo);
                            1: y = coord_t'(hi);
                            default: y = coord_t'($urandom_range(hi, lo));
                        endcase
                    end
                    else if (clustered)
                    begin
                        x = coord_t'($urandom_range(330));
                        y = coord_t'($urandom_range(330));
                    end
                    else
                    begin
                        x = coord_t'($urandom);
                        y = coord_t'($urandom);
                    end
                    send_request(brht_pkg::OP_QUERY, x, y, coord_t'($urandom),
                                 coord_t'($urandom));
                end
            end
            else
            begin
                repeat ($urandom_range(8, 3))
                    send_request(op_t'($urandom_range(3)), coord_t'($urandom),
                                 coord_t'($urandom), coord_t'($urandom),
                                 coord_t'($urandom));
            end
        end

        // drain
        in_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests (%0d queries, %0d appends) over five flow phases",
                 requests_sent, queries_sent, appends_sent);
        $display("checked %0d results: %0d hits, %0d appends dropped on a full table",
                 results_seen, hits_seen, drops_seen);
        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
